### sv/order_statistic_set_core_assert.svh
// order_statistic_set_core_assert.svh
// Assertion macros for the order statistic set; expects clock and reset in scope.
`ifndef ORDER_STATISTIC_SET_CORE_ASSERT_SVH
`define ORDER_STATISTIC_SET_CORE_ASSERT_SVH

// same-cycle implication
`define OSS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define OSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/osset_pkg.sv
// osset_pkg.sv
// Shared types and codes for the order statistic set. No dependencies.
`default_nettype none

package osset_pkg;

   localparam int KEY_W     = 31;
   localparam int FUNC_W    = 2;
   localparam int RANK_W    = 8;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 9;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANK = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic             cmp;      // latch compare flags against cmp_key
      logic [KEY_W-1:0] cmp_key;
      logic             ins;      // insert upd_key, shift up
      logic             ers;      // remove, shift down
      logic [KEY_W-1:0] upd_key;
   } cell_cmd_type;

endpackage

`default_nettype wire

### sv/order_statistic_set_core.sv
// order_statistic_set_core.sv
// Sorted key set with rank select, built as a row of osset_cell slots.
// Depends on osset_pkg and osset_cell.
//
//   channel | direction | handshake          | fields
//   req_    | in        | req_valid/req_stall | func, key, rank
//   rsp_    | out       | rsp_valid/rsp_stall | kth_key, status, count
//
// An item runs in steps: the accept edge latches per-slot compares, the PH_UPD
// step shifts the row, and the PH_SEL step loads the result register from the rank mux.
// A new item is accepted on that same load edge, so it overlaps the last item's select step.
// A stalled result holds the block in its select step until the register frees.
// Synchronous reset empties the set at once; no clearing pass.
`default_nettype none

module order_statistic_set_core #(
   parameter int CAPACITY = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [osset_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [osset_pkg::KEY_W-1:0]     req_key,
   input  wire logic [osset_pkg::RANK_W-1:0]    req_rank,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [osset_pkg::KEY_W-1:0]     rsp_kth_key,
   output logic      [osset_pkg::STAT_W-1:0]    rsp_status,
   output logic      [osset_pkg::CNT_OUT_W-1:0] rsp_count
);
   import osset_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW    = (CNT_W > RANK_W) ? CNT_W : RANK_W;
   localparam int OW    = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_UPD  = 2'd1;
   localparam logic [1:0] PH_SEL  = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic              ins_ff, ins_in;
   logic              ers_ff, ers_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              drop_ff, drop_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;
   logic [CNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic [KEY_W-1:0]    cell_key [CAPACITY];
   logic [CAPACITY-1:0] cell_valid, cell_lt, cell_eq;
   cell_cmd_type        cmd;

   logic             req_acc, out_free, present, full;
   logic [CW-1:0]    rank_x;
   logic [OW-1:0]    cnt_x;
   logic [IDX_W-1:0] sel_idx;
   logic             in_range;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((phase_ff == PH_IDLE) || ((phase_ff == PH_SEL) && out_free));
   assign req_acc   = req_valid && !req_stall;

   assign present = |cell_eq;
   assign full    = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      cmd.cmp     = req_acc;
      cmd.cmp_key = req_key;
      cmd.ins     = (phase_ff == PH_UPD) && ins_ff && !present && !full;
      cmd.ers     = (phase_ff == PH_UPD) && ers_ff && present;
      cmd.upd_key = key_ff;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_W-1:0] lk, rk;
      logic             lv, llt, rv;
      if (i == 0) begin : g_first
         assign lk  = '0;
         assign lv  = 1'b0;
         assign llt = 1'b1;
      end else begin : g_mid
         assign lk  = cell_key[i-1];
         assign lv  = cell_valid[i-1];
         assign llt = cell_lt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign rk = '0;
         assign rv = 1'b0;
      end else begin : g_rmid
         assign rk = cell_key[i+1];
         assign rv = cell_valid[i+1];
      end
      osset_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_key    (lk),
         .left_valid  (lv),
         .left_lt     (llt),
         .right_key   (rk),
         .right_valid (rv),
         .key         (cell_key[i]),
         .valid       (cell_valid[i]),
         .lt          (cell_lt[i]),
         .eq          (cell_eq[i])
      );
   end

   assign rank_x   = CW'(rank_ff);
   assign sel_idx  = rank_x[IDX_W-1:0];
   assign in_range = rank_x < CW'(count_ff);
   assign cnt_x    = OW'(count_ff);

   always_comb begin
      phase_in     = phase_ff;
      ins_in       = ins_ff;
      ers_in       = ers_ff;
      key_in       = key_ff;
      rank_in      = rank_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_key_in   = rsp_key_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      if (req_acc) begin
         ins_in  = (req_func == FUNC_INSERT) && (req_key != '0);
         ers_in  = (req_func == FUNC_ERASE) && (req_key != '0);
         key_in  = req_key;
         rank_in = req_rank;
      end

      case (phase_ff)
         PH_IDLE: begin
            if (req_acc) begin
               phase_in = PH_UPD;
            end
         end
         PH_UPD: begin
            drop_in = ins_ff && !present && full;
            if (cmd.ins) begin
               count_in = count_ff + CNT_W'(1);
            end else if (cmd.ers) begin
               count_in = count_ff - CNT_W'(1);
            end
            phase_in = PH_SEL;
         end
         PH_SEL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = in_range ? cell_key[sel_idx] : '0;
               rsp_cnt_in   = cnt_x[CNT_OUT_W-1:0];
               if (drop_ff) begin
                  rsp_stat_in = STAT_FULL;
               end else if (!in_range) begin
                  rsp_stat_in = STAT_RANK;
               end else begin
                  rsp_stat_in = STAT_OK;
               end
               phase_in = req_acc ? PH_UPD : PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ins_ff      <= ins_in;
      ers_ff      <= ers_in;
      key_ff      <= key_in;
      rank_ff     <= rank_in;
      drop_ff     <= drop_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kth_key = rsp_key_ff;
   assign rsp_status  = rsp_stat_ff;
   assign rsp_count   = rsp_cnt_ff;

endmodule

`default_nettype wire

### sv/osset_cell.sv
// osset_cell.sv
// One slot of the sorted row: holds a key, compares it, shifts with its neighbors.
// Depends on osset_pkg.
`default_nettype none

module osset_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire osset_pkg::cell_cmd_type    cmd,
   input  wire logic [osset_pkg::KEY_W-1:0] left_key,
   input  wire logic                       left_valid,
   input  wire logic                       left_lt,
   input  wire logic [osset_pkg::KEY_W-1:0] right_key,
   input  wire logic                       right_valid,
   output logic      [osset_pkg::KEY_W-1:0] key,
   output logic                            valid,
   output logic                            lt,
   output logic                            eq
);
   import osset_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic             valid_ff, valid_in;
   logic             lt_ff, lt_in;
   logic             eq_ff, eq_in;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (cmd.cmp) begin
         lt_in = valid_ff && (key_ff < cmd.cmp_key);
         eq_in = valid_ff && (key_ff == cmd.cmp_key);
      end
      if (cmd.ins && !lt_ff) begin
         if (left_lt) begin
            key_in   = cmd.upd_key;
            valid_in = 1'b1;
         end else begin
            key_in   = left_key;
            valid_in = left_valid;
         end
      end else if (cmd.ers && !lt_ff) begin
         key_in   = right_key;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key   = key_ff;
   assign valid = valid_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

`default_nettype wire

### sv/osset_chk.sv
// osset_chk.sv
// Port-level checks for order_statistic_set_core, bound to the top level.
// Depends on osset_pkg and order_statistic_set_core_assert.svh.
`default_nettype none

`include "order_statistic_set_core_assert.svh"

module osset_chk #(
   parameter int CAPACITY = 256
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic [osset_pkg::FUNC_W-1:0]    req_func,
   input wire logic [osset_pkg::KEY_W-1:0]     req_key,
   input wire logic [osset_pkg::RANK_W-1:0]    req_rank,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic [osset_pkg::KEY_W-1:0]     rsp_kth_key,
   input wire logic [osset_pkg::STAT_W-1:0]    rsp_status,
   input wire logic [osset_pkg::CNT_OUT_W-1:0] rsp_count
);
   import osset_pkg::*;

   localparam int OW = ($clog2(CAPACITY + 1) > CNT_OUT_W) ? $clog2(CAPACITY + 1) : CNT_OUT_W;
   localparam logic [OW-1:0] CAP_W = OW'(CAPACITY);
   localparam logic [CNT_OUT_W-1:0] CAP_LOW = CAP_W[CNT_OUT_W-1:0];

   logic [FUNC_W+KEY_W+RANK_W-1:0] req_payload;
   assign req_payload = {req_func, req_key, req_rank};

   `OSS_ASSERT_NOW(a_rank_zero, rsp_valid && (rsp_status == STAT_RANK), rsp_kth_key == '0)
   `OSS_ASSERT_NOW(a_ok_key, rsp_valid && (rsp_status == STAT_OK), rsp_kth_key != '0)
   `OSS_ASSERT_NOW(a_full_cnt, rsp_valid && (rsp_status == STAT_FULL), rsp_count == CAP_LOW)
   `OSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kth_key))
   `OSS_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_payload))

endmodule

bind order_statistic_set_core osset_chk #(.CAPACITY(CAPACITY)) u_osset_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_func    (req_func),
   .req_key     (req_key),
   .req_rank    (req_rank),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_kth_key (rsp_kth_key),
   .rsp_status  (rsp_status),
   .rsp_count   (rsp_count)
);

`default_nettype wire
